FILE: src/stkt_pkg.sv
// Shared types, status codes and helpers for the severity-ranked top-k tracker.
// No dependencies; imported by stkt_cell and severity_ranked_top_k_tracker.
package stkt_pkg;

	localparam int DEF_LIST_CAP = 8;

	localparam logic [1:0] ST_PASS = 2'd0;
	localparam logic [1:0] ST_WARN = 2'd1;
	localparam logic [1:0] ST_FAIL = 2'd2;
	localparam logic [1:0] ST_UNAV = 2'd3;

	localparam logic [1:0] RANK_FAIL  = 2'd3;
	localparam logic [1:0] RANK_WARN  = 2'd2;
	localparam logic [1:0] RANK_OTHER = 2'd1;

	localparam logic MODE_RECORD = 1'b0;
	localparam logic MODE_READ   = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [1:0]  status;
		logic [31:0] p95_us;
		logic [15:0] row_tag;
		logic [2:0]  read_index;
	} req_t;

	typedef struct packed {
		logic [31:0] tested_total;
		logic [31:0] fail_total;
		logic [31:0] warn_total;
		logic [31:0] unavail_total;
		logic [3:0]  list_size;
		logic        inserted;
		logic [2:0]  insert_position;
		logic        entry_valid;
		logic [1:0]  entry_status;
		logic [31:0] entry_p95_us;
		logic [15:0] entry_tag;
	} rsp_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] p95_us;
		logic [15:0] tag;
	} entry_t;

	// What one cell hands to the next one down the list.
	typedef struct packed {
		logic   beat;
		entry_t entry;
	} cell_link_t;

	function automatic logic [1:0] severity(input logic [1:0] st);
		logic [1:0] r;
		r = RANK_OTHER;
		if (st == ST_FAIL) begin
			r = RANK_FAIL;
		end else if (st == ST_WARN) begin
			r = RANK_WARN;
		end
		return r;
	endfunction

endpackage

FILE: src/stkt_cell.sv
// One list position of the tracker: holds an entry, ranks the incoming row
// against it and takes either the new row or its upper neighbor's entry. Uses stkt_pkg.
module stkt_cell
	import stkt_pkg::*;
(
	input  logic       clk,
	input  logic       shift_en,
	input  logic       occupied,
	input  entry_t     new_entry,
	input  cell_link_t prev,
	output cell_link_t next
);

	entry_t     entry_q;
	logic [1:0] new_rank;
	logic [1:0] cur_rank;
	logic       beats;

	always_comb begin
		new_rank = severity(new_entry.status);
		cur_rank = severity(entry_q.status);
		beats = (new_rank > cur_rank) ||
			((new_rank == cur_rank) && (new_entry.p95_us > entry_q.p95_us));
	end

	// An empty position always yields to the new row.
	assign next.beat  = !occupied || beats;
	assign next.entry = entry_q;

	always_ff @(posedge clk) begin
		if (shift_en && next.beat) begin
			entry_q <= prev.beat ? prev.entry : new_entry;
		end
	end

endmodule

FILE: src/severity_ranked_top_k_tracker.sv
// Top level of the severity-ranked top-k tracker: counters, list of stkt_cell
// positions and the registered response. Uses stkt_pkg and stkt_cell.
//
// Usage:
//   Drive a request on req and raise start; it is taken at a rising edge where
//   start is high and busy is low. busy stays low, so one request is taken every
//   cycle. mode MODE_RECORD counts the row and, if it is not a pass, places it in
//   the ranked list (fail before warn before unavailable, larger p95 first, ties
//   after older entries; a full list drops its last entry). mode MODE_READ
//   returns the entry at read_index and changes nothing.
//   The response appears on rsp in the cycle after the request is taken,
//   marked by done for exactly that cycle. Throughput: one request per cycle,
//   set by the single compare-and-shift step that all list cells perform in
//   parallel, each against its own entry and its upper neighbor.
//   The receiver cannot stall: a response is gone after its done cycle.
//   Reset clears all counters, the list size and done; stored entries are
//   not cleared, since only positions below the list size are ever read.
module severity_ranked_top_k_tracker
	import stkt_pkg::*;
#(
	parameter int LIST_CAP = DEF_LIST_CAP
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int IDX_W = (LIST_CAP > 1) ? $clog2(LIST_CAP) : 1;
	localparam int CNT_W = $clog2(LIST_CAP + 1);

	logic [31:0]      tested_q, fail_q, warn_q, unav_q;
	logic [31:0]      tested_d, fail_d, warn_d, unav_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             done_q;
	rsp_t             rsp_q;

	logic             accept;
	logic             record;
	logic             shift_en;
	entry_t           new_entry;
	cell_link_t       link [LIST_CAP+1];
	logic [LIST_CAP-1:0] occ;
	logic [LIST_CAP-1:0] take;
	logic             ins;
	logic [IDX_W-1:0] ins_pos;
	logic             rd_valid;
	entry_t           rd_entry;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign record = accept && (req.mode == MODE_RECORD);
	assign shift_en = record && (req.status != ST_PASS);

	assign new_entry.status = req.status;
	assign new_entry.p95_us = req.p95_us;
	assign new_entry.tag    = req.row_tag;

	// The top of the chain has no neighbor to hand down.
	assign link[0].beat  = 1'b0;
	assign link[0].entry = new_entry;

	for (genvar i = 0; i < LIST_CAP; i++) begin : g_cell
		assign occ[i] = (CNT_W'(i) < count_q);
		stkt_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.occupied (occ[i]),
			.new_entry(new_entry),
			.prev     (link[i]),
			.next     (link[i+1])
		);
		assign take[i] = link[i+1].beat;
	end

	// Insert position is the first cell that yields to the new row.
	always_comb begin
		ins_pos = '0;
		for (int i = LIST_CAP - 1; i >= 0; i--) begin
			if (take[i]) begin
				ins_pos = IDX_W'(i);
			end
		end
		ins = shift_en && (|take);
	end

	// Hold counters at their maximum.
	always_comb begin
		tested_d = tested_q;
		fail_d   = fail_q;
		warn_d   = warn_q;
		unav_d   = unav_q;
		count_d  = count_q;
		if (record) begin
			if (!(&tested_q)) tested_d = tested_q + 32'd1;
			unique case (req.status)
				ST_FAIL: if (!(&fail_q)) fail_d = fail_q + 32'd1;
				ST_WARN: if (!(&warn_q)) warn_d = warn_q + 32'd1;
				ST_UNAV: if (!(&unav_q)) unav_d = unav_q + 32'd1;
				default: ;
			endcase
		end
		if (ins && (count_q < CNT_W'(LIST_CAP))) begin
			count_d = count_q + CNT_W'(1);
		end
	end

	// Read mux: one position chosen by read_index.
	always_comb begin
		rd_valid = (int'(req.read_index) < int'(count_q)) &&
			(int'(req.read_index) < LIST_CAP);
		rd_entry = '0;
		for (int i = 0; i < LIST_CAP; i++) begin
			if (rd_valid && (int'(req.read_index) == i)) begin
				rd_entry = link[i+1].entry;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tested_q <= '0;
			fail_q   <= '0;
			warn_q   <= '0;
			unav_q   <= '0;
			count_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				tested_q <= tested_d;
				fail_q   <= fail_d;
				warn_q   <= warn_d;
				unav_q   <= unav_d;
				count_q  <= count_d;
			end
		end
	end

	// Response payload: no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.tested_total    <= tested_d;
			rsp_q.fail_total      <= fail_d;
			rsp_q.warn_total      <= warn_d;
			rsp_q.unavail_total   <= unav_d;
			rsp_q.list_size       <= 4'(count_d);
			rsp_q.inserted        <= ins;
			rsp_q.insert_position <= ins ? 3'(ins_pos) : 3'd0;
			rsp_q.entry_valid     <= (req.mode == MODE_READ) && rd_valid;
			if (req.mode == MODE_READ) begin
				rsp_q.entry_status <= rd_entry.status;
				rsp_q.entry_p95_us <= rd_entry.p95_us;
				rsp_q.entry_tag    <= rd_entry.tag;
			end else begin
				rsp_q.entry_status <= '0;
				rsp_q.entry_p95_us <= '0;
				rsp_q.entry_tag    <= '0;
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_resp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("response did not follow an accepted request");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(LIST_CAP))
		else $error("list size beyond capacity");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (count_q >= $past(count_q)))
		else $error("list size shrank");

	a_read_no_insert: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.mode == MODE_READ) |=> !rsp.inserted && (count_q == $past(count_q)))
		else $error("read request changed the list");

	a_record_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.mode == MODE_RECORD) |=> !rsp.entry_valid)
		else $error("record request returned an entry");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for severity_ranked_top_k_tracker: directed and random requests.
// Predicts every response internally and compares it field by field.
// Depends on stkt_pkg and the tracker RTL only.
module tb
	import stkt_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = DEF_LIST_CAP;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t rsp;

	severity_ranked_top_k_tracker #(
		.LIST_CAP(CAP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Predicted tracker state: running counters and the ranked worst list.
	logic [31:0] rows_seen = '0;
	logic [31:0] fails_seen = '0;
	logic [31:0] warns_seen = '0;
	logic [31:0] unavails_seen = '0;
	int unsigned held = 0;
	entry_t worst [CAP];

	// Responses predicted for accepted requests, oldest first.
	rsp_t awaiting [$];
	int unsigned mismatches = 0;

	// Requests left in the current sender burst; zero means open a new burst, possibly after a gap.
	int unsigned burst_left = 0;

	function automatic logic [31:0] bump(logic [31:0] v);
		// Hold at the top instead of wrapping.
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic logic [1:0] rank_of(logic [1:0] st);
		case (st)
			ST_FAIL: return RANK_FAIL;
			ST_WARN: return RANK_WARN;
			default: return RANK_OTHER;
		endcase
	endfunction

	// True when a new row sorts ahead of a stored entry. Equal keys do not,
	// so a tie lands behind the entries already held.
	function automatic bit outranks(logic [1:0] st, logic [31:0] p95, entry_t e);
		logic [1:0] mine;
		logic [1:0] theirs;
		mine = rank_of(st);
		theirs = rank_of(e.status);
		return (mine > theirs) || (mine == theirs && p95 > e.p95_us);
	endfunction

	// Apply one request to the predicted state and return the response it
	// must produce. Record mode counts and ranks; read mode only looks.
	function automatic rsp_t track_request(req_t r);
		rsp_t o;
		int unsigned pos;
		int unsigned last;
		o = '0;
		if (r.mode == MODE_RECORD) begin
			rows_seen = bump(rows_seen);
			case (r.status)
				ST_FAIL: fails_seen = bump(fails_seen);
				ST_WARN: warns_seen = bump(warns_seen);
				ST_UNAV: unavails_seen = bump(unavails_seen);
				default: ;
			endcase
			if (r.status != ST_PASS) begin
				// Walk down the list until the row beats an entry.
				pos = 0;
				while (pos < held && !outranks(r.status, r.p95_us, worst[pos])) begin
					pos++;
				end
				// Past the end of a full list: drop the row.
				if (pos < CAP) begin
					last = (held < CAP) ? held : CAP - 1;
					for (int k = last; k > pos; k--) begin
						worst[k] = worst[k - 1];
					end
					worst[pos] = '{status: r.status, p95_us: r.p95_us, tag: r.row_tag};
					if (held < CAP) begin
						held++;
					end
					o.inserted = 1'b1;
					o.insert_position = pos[2:0];
				end
			end
		end else if (r.read_index < held) begin
			o.entry_valid = 1'b1;
			o.entry_status = worst[r.read_index].status;
			o.entry_p95_us = worst[r.read_index].p95_us;
			o.entry_tag = worst[r.read_index].tag;
		end
		o.tested_total = rows_seen;
		o.fail_total = fails_seen;
		o.warn_total = warns_seen;
		o.unavail_total = unavails_seen;
		o.list_size = held[3:0];
		return o;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Response checker and request monitor share one edge. Retire the
	// response first, then queue the prediction for a request taken now,
	// so a back-to-back stream never sees its own prediction early.
	always @(posedge clk) begin : scoreboard
		rsp_t want;
		if (done === 1'b1) begin
			if (awaiting.size() == 0) begin
				$error("done: response with no request outstanding");
				mismatches++;
			end else begin
				want = awaiting.pop_front();
				check_field("tested_total", want.tested_total, rsp.tested_total);
				check_field("fail_total", want.fail_total, rsp.fail_total);
				check_field("warn_total", want.warn_total, rsp.warn_total);
				check_field("unavail_total", want.unavail_total, rsp.unavail_total);
				check_field("list_size", 32'(want.list_size), 32'(rsp.list_size));
				check_field("inserted", 32'(want.inserted), 32'(rsp.inserted));
				check_field("insert_position", 32'(want.insert_position),
					32'(rsp.insert_position));
				check_field("entry_valid", 32'(want.entry_valid), 32'(rsp.entry_valid));
				check_field("entry_status", 32'(want.entry_status),
					32'(rsp.entry_status));
				check_field("entry_p95_us", want.entry_p95_us, rsp.entry_p95_us);
				check_field("entry_tag", 32'(want.entry_tag), 32'(rsp.entry_tag));
			end
		end
		if (start === 1'b1 && busy === 1'b0) begin
			awaiting.push_back(track_request(req));
		end
	end

	// Send one request. Open a new burst after a random gap when the
	// current one is used up; inside a burst keep start high throughout.
	task automatic send_request(input req_t r);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			// Mostly short bursts, now and then a long unbroken stretch.
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
		end
		burst_left--;
		req <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// Build a record request; read_index is don't-care, so randomize it.
	function automatic req_t mk_row(logic [1:0] st, logic [31:0] p95, logic [15:0] tag);
		req_t r;
		r.mode = MODE_RECORD;
		r.status = st;
		r.p95_us = p95;
		r.row_tag = tag;
		r.read_index = 3'($urandom);
		return r;
	endfunction

	// Build a read request; the row fields are ignored, so randomize them.
	function automatic req_t mk_peek(logic [2:0] idx);
		req_t r;
		r.mode = MODE_READ;
		r.status = 2'($urandom);
		r.p95_us = $urandom;
		r.row_tag = 16'($urandom);
		r.read_index = idx;
		return r;
	endfunction

	// Reads on an empty list return nothing valid.
	task automatic test_empty_list_reads();
		send_request(mk_peek(3'd0));
		send_request(mk_peek(3'd7));
	endtask

	// Pass rows bump the row count only and leave the list alone.
	task automatic test_pass_rows();
		send_request(mk_row(ST_PASS, 32'd0, 16'h0000));
		send_request(mk_row(ST_PASS, 32'hFFFF_FFFF, 16'hFFFF));
	endtask

	// Fill the list with every severity, p95 extremes and exact ties.
	task automatic test_ranking_and_ties();
		send_request(mk_row(ST_FAIL, 32'hFFFF_FFFF, 16'hFFFF));
		send_request(mk_row(ST_WARN, 32'd0, 16'h0000));
		send_request(mk_row(ST_UNAV, 32'd0, 16'h0001));
		send_request(mk_row(ST_UNAV, 32'd0, 16'h0002));
		send_request(mk_row(ST_FAIL, 32'd0, 16'h0003));
		send_request(mk_row(ST_FAIL, 32'hFFFF_FFFF, 16'h0004));
		send_request(mk_row(ST_WARN, 32'd5, 16'h0005));
		send_request(mk_row(ST_UNAV, 32'hFFFF_FFFF, 16'h0006));
	endtask

	// Full list: a row tying the last entry is not kept, a higher one
	// pushes the last entry out. Then read back every position.
	task automatic test_full_list();
		send_request(mk_row(ST_UNAV, 32'd0, 16'h0007));
		send_request(mk_row(ST_FAIL, 32'd1, 16'h0008));
		for (int i = 0; i < 8; i++) begin
			send_request(mk_peek(3'(i)));
		end
	endtask

	// Random low-severity traffic with small p95 values so ties are common.
	task automatic test_random_low_severity();
		req_t r;
		for (int i = 0; i < 150; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				r = mk_peek(3'($urandom_range(0, 7)));
			end else begin
				case ($urandom_range(0, 2))
					0: r = mk_row(ST_PASS, $urandom, 16'($urandom));
					1: r = mk_row(ST_WARN, $urandom_range(0, 63), 16'($urandom));
					default: r = mk_row(ST_UNAV, $urandom_range(0, 63), 16'($urandom));
				endcase
				if ($urandom_range(0, 7) == 0) begin
					r.p95_us = $urandom;
				end
			end
			send_request(r);
		end
	endtask

	// Random mix of every status. Let p95 mostly climb so new rows keep
	// displacing old ones at varying positions; sprinkle in full-range values.
	task automatic test_random_mixed();
		req_t r;
		logic [31:0] p95;
		for (int i = 0; i < 250; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				r = mk_peek(3'($urandom_range(0, 7)));
			end else begin
				p95 = ($urandom_range(0, 3) == 0) ? $urandom
					: 32'(i * 4 + $urandom_range(0, 15));
				r = mk_row(2'($urandom), p95, 16'($urandom));
			end
			send_request(r);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list_reads();
		test_pass_rows();
		test_ranking_and_ties();
		test_full_list();
		test_random_low_severity();
		test_random_mixed();

		// Drain: stop requesting, wait for outstanding responses, then keep
		// clocking to catch any stray done.
		start <= 1'b0;
		for (int i = 0; i < 64 && awaiting.size() != 0; i++) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
		if (awaiting.size() != 0) begin
			$error("done: %0d responses never arrived", awaiting.size());
			mismatches++;
		end

		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Watchdog: a correct run ends far sooner than this.
	initial begin
		#2ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: severity_ranked_top_k_tracker.f
src/stkt_pkg.sv
src/stkt_cell.sv
src/severity_ranked_top_k_tracker.sv
dv/tb.sv
